@@ rtl/pps_pkg.sv @@
// Package for the payload power sequencer: mode codes, register indexes,
// register reset values and the structs passed between modules. No dependencies.
package pps_pkg;

    localparam int unsigned RPM_W  = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_GND_WAIT = 2'd1,
        MODE_ON       = 2'd2,
        MODE_WAIT_OFF = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_RPM_GROUND     = 3'd0,
        CFG_AIR_ON_RPM        = 3'd1,
        CFG_STABLE_RPM        = 3'd2,
        CFG_OFF_RPM           = 3'd3,
        CFG_GROUND_WAIT_MS    = 3'd4,
        CFG_LOW_POWER_WAIT_MS = 3'd5
    } t_cfg_idx;

    localparam logic [RPM_W-1:0]  RST_ON_RPM_GROUND     = 16'd2200;
    localparam logic [RPM_W-1:0]  RST_AIR_ON_RPM        = 16'd2400;
    localparam logic [RPM_W-1:0]  RST_STABLE_RPM        = 16'd2300;
    localparam logic [RPM_W-1:0]  RST_OFF_RPM           = 16'd1000;
    localparam logic [TIME_W-1:0] RST_GROUND_WAIT_MS    = 32'd30000;
    localparam logic [TIME_W-1:0] RST_LOW_POWER_WAIT_MS = 32'd5000;

    typedef struct packed {
        logic [RPM_W-1:0]  on_rpm_ground;
        logic [RPM_W-1:0]  air_on_rpm;
        logic [RPM_W-1:0]  stable_rpm;
        logic [RPM_W-1:0]  off_rpm;
        logic [TIME_W-1:0] ground_wait_ms;
        logic [TIME_W-1:0] low_power_wait_ms;
    } t_cfg;

    typedef struct packed {
        logic [RPM_W-1:0]  rpm;
        logic [TIME_W-1:0] now_ms;
        logic              on_ground;
    } t_sample;

endpackage

@@ rtl/pps_sample_if.sv @@
// Sample channel: valid/ready handshake carrying one speed sample.
// Depends on pps_pkg for field widths.
interface pps_sample_if;
    logic                     valid;
    logic                     ready;
    logic [pps_pkg::RPM_W-1:0]  rpm;
    logic [pps_pkg::TIME_W-1:0] now_ms;
    logic                     on_ground;

    modport source (output valid, output rpm, output now_ms, output on_ground, input ready);
    modport sink   (input valid, input rpm, input now_ms, input on_ground, output ready);
endinterface

@@ rtl/pps_result_if.sv @@
// Result channel: valid/ready handshake carrying power enable and mode.
// No package dependencies.
interface pps_result_if;
    logic       valid;
    logic       ready;
    logic       power_enable;
    logic [1:0] mode;

    modport source (output valid, output power_enable, output mode, input ready);
    modport sink   (input valid, input power_enable, input mode, output ready);
endinterface

@@ rtl/payload_power_sequencer_top.sv @@
// Payload power sequencer top level: sample input register, mode FSM and
// result register. Depends on pps_pkg, pps_sample_if, pps_result_if,
// pps_cfg_regs and pps_mode_fsm.
// A sample passes through one register stage in, the mode logic and one result
//   register out before its result is offered.
// Throughput: one sample per cycle while the result receiver is ready; the FSM's
//   next-state path is combinational.
// Reset (synchronous, active low): mode off, wait start zero, thresholds and
//   waits at their default values, both pipeline stages empty.
module payload_power_sequencer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [pps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pps_sample_if.sink                         i_sample,
    pps_result_if.source                       o_result
);

    pps_pkg::t_cfg     cfg;
    pps_pkg::t_mode    mode_next;

    // input stage
    logic              r_in_valid;
    pps_pkg::t_sample  r_in;

    // result stage
    logic              r_out_valid;
    logic              r_out_pwr;
    pps_pkg::t_mode    r_out_mode;

    logic              advance;
    logic              in_xfer;

    // the input stage moves into the result register when that register is
    // empty or its contents are being taken this cycle
    assign advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || advance;
    assign in_xfer = i_sample.valid && i_sample.ready;

    pps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // state updates only when the sample leaves the input stage, so each
    // sample sees exactly the state left by the one before it
    pps_mode_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_cfg       (cfg),
        .i_sample    (r_in),
        .o_mode_next (mode_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.rpm       <= i_sample.rpm;
            r_in.now_ms    <= i_sample.now_ms;
            r_in.on_ground <= i_sample.on_ground;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // power is on in mode on and in wait-off
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_mode <= mode_next;
            r_out_pwr  <= (mode_next == pps_pkg::MODE_ON) ||
                          (mode_next == pps_pkg::MODE_WAIT_OFF);
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.power_enable = r_out_pwr;
    assign o_result.mode         = r_out_mode;

    // a stalled sample stays in the input stage
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("input stage lost a stalled sample");

    // power enable tracks the mode on every result transfer
    a_pwr_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_pwr == ((r_out_mode == pps_pkg::MODE_ON) ||
                                      (r_out_mode == pps_pkg::MODE_WAIT_OFF)))
        else $error("power enable disagrees with mode");

    // a held result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result.ready |=> r_out_valid && $stable(r_out_mode))
        else $error("pending result overwritten");

endmodule

@@ rtl/pps_cfg_regs.sv @@
// Configuration register file for the power sequencer thresholds and waits.
// Depends on pps_pkg.
module pps_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [pps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output pps_pkg::t_cfg                      o_cfg
);

    pps_pkg::t_cfg r_cfg;
    pps_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (pps_pkg::t_cfg_idx'(i_cfg_index))
                pps_pkg::CFG_ON_RPM_GROUND:
                    n_cfg.on_rpm_ground = i_cfg_data[pps_pkg::RPM_W-1:0];
                pps_pkg::CFG_AIR_ON_RPM:
                    n_cfg.air_on_rpm = i_cfg_data[pps_pkg::RPM_W-1:0];
                pps_pkg::CFG_STABLE_RPM:
                    n_cfg.stable_rpm = i_cfg_data[pps_pkg::RPM_W-1:0];
                pps_pkg::CFG_OFF_RPM:
                    n_cfg.off_rpm = i_cfg_data[pps_pkg::RPM_W-1:0];
                pps_pkg::CFG_GROUND_WAIT_MS:
                    n_cfg.ground_wait_ms = i_cfg_data[pps_pkg::TIME_W-1:0];
                pps_pkg::CFG_LOW_POWER_WAIT_MS:
                    n_cfg.low_power_wait_ms = i_cfg_data[pps_pkg::TIME_W-1:0];
                default: ; // unknown index: write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_rpm_ground     <= pps_pkg::RST_ON_RPM_GROUND;
            r_cfg.air_on_rpm        <= pps_pkg::RST_AIR_ON_RPM;
            r_cfg.stable_rpm        <= pps_pkg::RST_STABLE_RPM;
            r_cfg.off_rpm           <= pps_pkg::RST_OFF_RPM;
            r_cfg.ground_wait_ms    <= pps_pkg::RST_GROUND_WAIT_MS;
            r_cfg.low_power_wait_ms <= pps_pkg::RST_LOW_POWER_WAIT_MS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/pps_mode_fsm.sv @@
// Mode state machine: holds mode and wait start time, computes the next mode
// for one registered sample. Depends on pps_pkg.
module pps_mode_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  pps_pkg::t_cfg      i_cfg,
    input  pps_pkg::t_sample   i_sample,
    output pps_pkg::t_mode     o_mode_next
);

    pps_pkg::t_mode               r_mode;
    pps_pkg::t_mode               n_mode;
    logic [pps_pkg::TIME_W-1:0]   r_wait_start;
    logic [pps_pkg::TIME_W-1:0]   n_wait_start;

    logic [pps_pkg::TIME_W-1:0]   elapsed;
    logic                         gnd;
    logic                         ge_on_gnd;
    logic                         ge_on_air;
    logic                         ge_stable;
    logic                         ge_off;
    logic                         gnd_done;
    logic                         low_done;

    // wrapping elapsed time since the wait began
    assign elapsed   = i_sample.now_ms - r_wait_start;
    assign gnd       = i_sample.on_ground;
    assign ge_on_gnd = i_sample.rpm >= i_cfg.on_rpm_ground;
    assign ge_on_air = i_sample.rpm >= i_cfg.air_on_rpm;
    assign ge_stable = i_sample.rpm >= i_cfg.stable_rpm;
    assign ge_off    = i_sample.rpm >= i_cfg.off_rpm;
    assign gnd_done  = elapsed >= i_cfg.ground_wait_ms;
    assign low_done  = elapsed >= i_cfg.low_power_wait_ms;

    always_comb begin
        n_mode       = r_mode;
        n_wait_start = r_wait_start;
        case (r_mode)
            pps_pkg::MODE_OFF: begin
                if (gnd && ge_on_gnd) begin
                    n_mode       = pps_pkg::MODE_GND_WAIT;
                    n_wait_start = i_sample.now_ms;
                end else if (!gnd && ge_on_air) begin
                    n_mode = pps_pkg::MODE_ON;
                end
            end
            pps_pkg::MODE_GND_WAIT: begin
                if (!gnd && ge_on_air && gnd_done) begin
                    n_mode       = pps_pkg::MODE_ON;
                    n_wait_start = '0;
                end else if (!ge_on_gnd) begin
                    n_mode       = pps_pkg::MODE_OFF;
                    n_wait_start = '0;
                end else if (gnd_done) begin
                    n_mode       = pps_pkg::MODE_ON;
                    n_wait_start = '0;
                end
            end
            pps_pkg::MODE_ON: begin
                if (ge_off && !ge_stable && !gnd) begin
                    n_mode       = pps_pkg::MODE_WAIT_OFF;
                    n_wait_start = i_sample.now_ms;
                end else if (!ge_off) begin
                    n_mode = pps_pkg::MODE_OFF;
                end
            end
            pps_pkg::MODE_WAIT_OFF: begin
                if (ge_stable || gnd) begin
                    n_mode       = pps_pkg::MODE_ON;
                    n_wait_start = '0;
                end else if (!ge_off || low_done) begin
                    n_mode       = pps_pkg::MODE_OFF;
                    n_wait_start = '0;
                end
            end
            default: begin
                n_mode       = pps_pkg::MODE_OFF;
                n_wait_start = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= pps_pkg::MODE_OFF;
            r_wait_start <= '0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_wait_start <= n_wait_start;
        end
    end

    assign o_mode_next = n_mode;

    // no wait is pending while off or on
    a_wait_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == pps_pkg::MODE_OFF || r_mode == pps_pkg::MODE_ON) |-> r_wait_start == '0)
        else $error("wait start not cleared outside a wait mode");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_mode) && $stable(r_wait_start))
        else $error("mode state changed without a sample");

    a_no_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == pps_pkg::MODE_OFF |=> r_mode != pps_pkg::MODE_WAIT_OFF)
        else $error("off went straight to wait-off");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for payload_power_sequencer_top: directed and random samples
// checked against an in-bench mode predictor. Depends on pps_pkg, pps_sample_if,
// pps_result_if and the sequencer RTL.
module tb;
    import pps_pkg::*;

    // Spare register indexes: the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // Far beyond the slowest legal run (receiver stalls on most cycles).
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_PER_PHASE = 150;
    localparam int unsigned PHASES = 11;

    typedef struct packed {
        logic  power_enable;
        t_mode mode;
    } t_status;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pps_sample_if sample_ch ();
    pps_result_if result_ch ();

    payload_power_sequencer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (sample_ch),
        .o_result    (result_ch)
    );

    // Samples waiting for the driver, and statuses waiting for the DUT.
    t_sample pending_samples[$];
    t_status expected_status[$];

    // Predictor copy of the block's registers and state.
    t_cfg              model_cfg;
    t_mode             model_mode;
    logic [TIME_W-1:0] model_wait_start;

    // Stimulus generator state.
    logic [RPM_W-1:0]  rpm_marks [4];
    logic [RPM_W-1:0]  gen_rpm;
    logic [TIME_W-1:0] gen_now;
    logic              gen_ground;
    int unsigned       time_step_max;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        sample_taken;
    int unsigned fail_count;
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mode machine predictor: updates model state for one accepted sample and
    // returns the new mode. Elapsed time wraps at 32 bits by construction.
    function automatic t_mode advance_power_mode(input t_sample s);
        logic [TIME_W-1:0] elapsed;
        elapsed = s.now_ms - model_wait_start;
        case (model_mode)
            MODE_OFF: begin
                if (s.on_ground && s.rpm >= model_cfg.on_rpm_ground) begin
                    model_mode       = MODE_GND_WAIT;
                    model_wait_start = s.now_ms;
                end else if (!s.on_ground && s.rpm >= model_cfg.air_on_rpm) begin
                    model_mode = MODE_ON;
                end
            end
            MODE_GND_WAIT: begin
                // Liftoff at speed after the wait takes priority over a speed drop.
                if (!s.on_ground && s.rpm >= model_cfg.air_on_rpm
                        && elapsed >= model_cfg.ground_wait_ms) begin
                    model_wait_start = '0;
                    model_mode       = MODE_ON;
                end else if (s.rpm < model_cfg.on_rpm_ground) begin
                    model_wait_start = '0;
                    model_mode       = MODE_OFF;
                end else if (elapsed >= model_cfg.ground_wait_ms) begin
                    model_wait_start = '0;
                    model_mode       = MODE_ON;
                end
            end
            MODE_ON: begin
                if (s.rpm >= model_cfg.off_rpm && s.rpm < model_cfg.stable_rpm
                        && !s.on_ground) begin
                    model_wait_start = s.now_ms;
                    model_mode       = MODE_WAIT_OFF;
                end else if (s.rpm < model_cfg.off_rpm) begin
                    model_mode = MODE_OFF;
                end
            end
            default: begin
                if (s.rpm >= model_cfg.stable_rpm || s.on_ground) begin
                    model_wait_start = '0;
                    model_mode       = MODE_ON;
                end else if (s.rpm < model_cfg.off_rpm
                        || elapsed >= model_cfg.low_power_wait_ms) begin
                    model_wait_start = '0;
                    model_mode       = MODE_OFF;
                end
            end
        endcase
        return model_mode;
    endfunction

    // Driver: presents the next pending sample at the falling edge, holding valid
    // high across back-to-back transfers. Receiver ready toggles independently.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!sample_ch.valid || sample_taken) begin
                if (pending_samples.size() != 0
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    sample_ch.rpm       <= pending_samples[0].rpm;
                    sample_ch.now_ms    <= pending_samples[0].now_ms;
                    sample_ch.on_ground <= pending_samples[0].on_ground;
                    sample_ch.valid     <= 1'b1;
                    void'(pending_samples.pop_front());
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: checks each result transfer against the oldest expectation, then
    // predicts the status for any sample transfer on the same edge.
    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        t_sample s;
        t_mode   m;
        logic    took;
        took = 1'b0;
        if (i_rst_n) begin
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                got.power_enable = result_ch.power_enable;
                got.mode         = t_mode'(result_ch.mode);
                if (expected_status.size() == 0) begin
                    $error("result transfer with no sample outstanding: mode %0d",
                           result_ch.mode);
                    fail_count++;
                end else begin
                    want = expected_status.pop_front();
                    if (got.power_enable !== want.power_enable) begin
                        $error("power_enable: expected %0d, actual %0d",
                               want.power_enable, result_ch.power_enable);
                        fail_count++;
                    end
                    if (got.mode !== want.mode) begin
                        $error("mode: expected %0d, actual %0d", want.mode,
                               result_ch.mode);
                        fail_count++;
                    end
                end
            end
            if (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) begin
                s.rpm       = sample_ch.rpm;
                s.now_ms    = sample_ch.now_ms;
                s.on_ground = sample_ch.on_ground;
                m = advance_power_mode(s);
                want.mode         = m;
                want.power_enable = (m == MODE_ON || m == MODE_WAIT_OFF);
                expected_status.push_back(want);
                took = 1'b1;
            end
        end
        sample_taken <= took;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_sample(input logic [RPM_W-1:0] rpm, input logic [TIME_W-1:0] now,
                              input logic gnd);
        t_sample s;
        s.rpm       = rpm;
        s.now_ms    = now;
        s.on_ground = gnd;
        pending_samples.push_back(s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    // Writes all six registers (junk in the unused high bits of the speed ones),
    // pokes the spare indexes, and retunes the stimulus to the new thresholds.
    task automatic apply_settings(input logic [RPM_W-1:0] gr, input logic [RPM_W-1:0] air,
                                  input logic [RPM_W-1:0] stab, input logic [RPM_W-1:0] off,
                                  input logic [TIME_W-1:0] gw, input logic [TIME_W-1:0] lw);
        logic [31:0] noise;
        int unsigned span;
        noise = $urandom();
        write_reg(CFG_ON_RPM_GROUND, {noise[31:16], gr});
        write_reg(CFG_AIR_ON_RPM, {noise[15:0], air});
        noise = $urandom();
        write_reg(CFG_STABLE_RPM, {noise[31:16], stab});
        write_reg(CFG_OFF_RPM, {noise[15:0], off});
        write_reg(CFG_GROUND_WAIT_MS, gw);
        write_reg(CFG_LOW_POWER_WAIT_MS, lw);
        write_reg(CFG_SPARE_6, $urandom());
        write_reg(CFG_SPARE_7, $urandom());
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        model_cfg.on_rpm_ground     = gr;
        model_cfg.air_on_rpm        = air;
        model_cfg.stable_rpm        = stab;
        model_cfg.off_rpm           = off;
        model_cfg.ground_wait_ms    = gw;
        model_cfg.low_power_wait_ms = lw;
        rpm_marks[0] = gr;
        rpm_marks[1] = air;
        rpm_marks[2] = stab;
        rpm_marks[3] = off;
        span = (gw > lw) ? gw : lw;
        if (span > 90000) span = 90000;
        time_step_max = span / 3 + 2;
    endtask

    // Random samples: speed mostly hugs a threshold, ground flag is sticky so
    // flights and ground runs last, time mostly creeps forward so waits expire.
    task automatic queue_random_samples(input int unsigned count);
        int unsigned r;
        int          d;
        for (int unsigned n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                d = int'($urandom_range(0, 4)) - 2;
                gen_rpm = RPM_W'(rpm_marks[2'($urandom_range(0, 3))] + d);
            end else if (r < 84) begin
                if (r < 78) gen_rpm = gen_rpm;
                else gen_rpm = '0;
            end else if (r < 90) begin
                gen_rpm = '1;
            end else begin
                gen_rpm = RPM_W'($urandom());
            end

            if ($urandom_range(0, 99) < 8) gen_ground = ~gen_ground;

            r = $urandom_range(0, 99);
            if (r < 72) gen_now = gen_now + $urandom_range(0, time_step_max);
            else if (r < 80) gen_now = gen_now;
            else if (r < 86) gen_now = gen_now - $urandom_range(1, 3);
            else if (r < 92) gen_now = gen_now + (r[0] ? model_cfg.ground_wait_ms
                                                        : model_cfg.low_power_wait_ms);
            else if (r < 96) gen_now = $urandom();
            else gen_now = 32'hFFFF_FFFF - $urandom_range(0, 8);

            add_sample(gen_rpm, gen_now, gen_ground);
        end
    endtask

    // Idle point: nothing queued, nothing on the wire, nothing outstanding,
    // then a settling pause.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || sample_ch.valid === 1'b1
                || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [RPM_W-1:0] base;
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_index         = '0;
        i_cfg_data          = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.rpm       = '0;
        sample_ch.now_ms    = '0;
        sample_ch.on_ground = 1'b0;
        result_ch.ready     = 1'b0;
        sample_taken        = 1'b0;
        fail_count          = 0;
        cycle_count         = 0;
        send_idle_pct       = 6;
        recv_idle_pct       = 79;

        model_cfg.on_rpm_ground     = RST_ON_RPM_GROUND;
        model_cfg.air_on_rpm        = RST_AIR_ON_RPM;
        model_cfg.stable_rpm        = RST_STABLE_RPM;
        model_cfg.off_rpm           = RST_OFF_RPM;
        model_cfg.ground_wait_ms    = RST_GROUND_WAIT_MS;
        model_cfg.low_power_wait_ms = RST_LOW_POWER_WAIT_MS;
        model_mode       = MODE_OFF;
        model_wait_start = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed run on the reset thresholds: ground spin-up with the wait
        // just short and just met, air on/off paths, low-speed timeout, ground
        // cancel of the off wait, and a ground wait that spans the timer wrap.
        add_sample(16'd0,     32'd0,     1'b0);
        add_sample(16'd2200,  32'd100,   1'b1);
        add_sample(16'd2199,  32'd200,   1'b1);
        add_sample(16'd2200,  32'd300,   1'b1);
        add_sample(16'hFFFF,  32'd30299, 1'b1);
        add_sample(16'd2200,  32'd30300, 1'b1);
        add_sample(16'd2299,  32'd30400, 1'b0);
        add_sample(16'd2300,  32'd30500, 1'b0);
        add_sample(16'd1000,  32'd30600, 1'b0);
        add_sample(16'd1500,  32'd35599, 1'b0);
        add_sample(16'd1500,  32'd35600, 1'b0);
        add_sample(16'd2399,  32'd35700, 1'b0);
        add_sample(16'd2400,  32'd35800, 1'b0);
        add_sample(16'd999,   32'd35900, 1'b0);
        add_sample(16'hFFFF,  32'd36000, 1'b0);
        add_sample(16'd1200,  32'd36100, 1'b0);
        add_sample(16'd1200,  32'd36200, 1'b1);
        add_sample(16'd500,   32'd36300, 1'b0);
        add_sample(16'd3000,  32'hFFFF_F000, 1'b1);
        add_sample(16'd3000,  32'h0000_5000, 1'b1);
        add_sample(16'd2400,  32'h0000_6530, 1'b0);
        add_sample(16'd2000,  32'h0000_6600, 1'b0);
        add_sample(16'd2000,  32'hFFFF_FFFF, 1'b0);
        add_sample(16'd0,     32'hFFFF_FFFF, 1'b1);
        add_sample(16'd2400,  32'hFFFF_FFFF, 1'b1);

        gen_rpm    = '0;
        gen_now    = $urandom();
        gen_ground = 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            // Idling schedule: slow receiver, then slow sender, then full rate.
            if (p == 4) begin
                send_idle_pct = 79;
                recv_idle_pct = 6;
            end
            if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: apply_settings(16'd2200, 16'd2400, 16'd2300, 16'd1000,
                                  32'd30000, 32'd5000);
                1: apply_settings(16'd2200, 16'd2400, 16'd2300, 16'd1000, 32'd12, 32'd6);
                2: apply_settings('0, '0, '0, '0, '0, '0);
                3: apply_settings('1, '1, '1, '1, '1, '1);
                // thresholds out of their usual order
                4: apply_settings(16'd3000, 16'd1500, 16'd1000, 16'd2000, 32'd9, 32'd4);
                5: apply_settings(RPM_W'($urandom_range(0, 65535)),
                                  RPM_W'($urandom_range(0, 65535)),
                                  RPM_W'($urandom_range(0, 65535)),
                                  RPM_W'($urandom_range(0, 65535)),
                                  $urandom_range(0, 40), $urandom_range(0, 40));
                6: begin
                    // thresholds packed within a few rpm of each other
                    base = RPM_W'($urandom_range(3, 65532));
                    apply_settings(RPM_W'(base + $urandom_range(0, 6) - 3),
                                   RPM_W'(base + $urandom_range(0, 6) - 3),
                                   RPM_W'(base + $urandom_range(0, 6) - 3),
                                   RPM_W'(base + $urandom_range(0, 6) - 3),
                                   $urandom_range(0, 15), $urandom_range(0, 15));
                end
                7: apply_settings('0, '0, '0, '0, '1, '1);
                8: apply_settings('1, '1, '1, '1, '0, '0);
                9: apply_settings(RPM_W'($urandom()), RPM_W'($urandom()),
                                  RPM_W'($urandom()), RPM_W'($urandom()),
                                  $urandom(), $urandom());
                default: apply_settings(16'd2200, 16'd2400, 16'd2300, 16'd1000,
                                        32'd100, 32'd40);
            endcase
            queue_random_samples(RANDOM_PER_PHASE);
        end
        wait_idle();

        if (fail_count == 0 && expected_status.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pps_pkg.sv
rtl/pps_sample_if.sv
rtl/pps_result_if.sv
rtl/pps_cfg_regs.sv
rtl/pps_mode_fsm.sv
rtl/payload_power_sequencer_top.sv
test/tb.sv
